// ===== sv/dds_pkg.sv =====
// Shared types, codes and constants for the dedoppler drift search block.
// Used by the top level, dds_ctrl and dds_dp; depends on nothing else.
`timescale 1ns / 1ps

package dds_pkg;

  // Default store and search limits.
  localparam int DDS_MAX_ROWS  = 64;
  localparam int DDS_MAX_BINS  = 1024;
  localparam int DDS_MAX_DRIFT = 32;

  // Field widths fixed by the interface.
  localparam int DDS_ROWS_W   = 7;
  localparam int DDS_BINS_W   = 11;
  localparam int DDS_DRIFT_W  = 6;
  localparam int DDS_SCALE_W  = 16;
  localparam int DDS_TIDX_W   = 6;
  localparam int DDS_FIDX_W   = 10;
  localparam int DDS_SAMPLE_W = 16;
  localparam int DDS_SNR_W    = 19;
  localparam int DDS_BDRIFT_W = 7;
  localparam int DDS_CIDX_W   = 2;
  localparam int DDS_CDATA_W  = 16;

  // Path sum over up to 127 rows of 16-bit samples, and its scaled product.
  localparam int DDS_SUM_W  = 23;
  localparam int DDS_PROD_W = DDS_SUM_W + DDS_SCALE_W + 1;

  localparam int DDS_SNR_MAX = 262143;
  localparam int DDS_SNR_MIN = -262144;

  // Register reset values.
  localparam logic [DDS_ROWS_W-1:0]  DDS_ROWS_RST  = 7'd16;
  localparam logic [DDS_BINS_W-1:0]  DDS_BINS_RST  = 11'd1024;
  localparam logic [DDS_DRIFT_W-1:0] DDS_DRIFT_RST = 6'd8;
  localparam logic [DDS_SCALE_W-1:0] DDS_SCALE_RST = 16'd16384;

  // Configuration register indexes.
  localparam logic [DDS_CIDX_W-1:0] CFG_TIME_ROWS     = 2'd0;
  localparam logic [DDS_CIDX_W-1:0] CFG_FREQ_BINS     = 2'd1;
  localparam logic [DDS_CIDX_W-1:0] CFG_MAX_DRIFT     = 2'd2;
  localparam logic [DDS_CIDX_W-1:0] CFG_INV_SQRT_ROWS = 2'd3;

  // Input function codes.
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Result status codes.
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_BAD_CFG = 2'd1;
  localparam logic [1:0] STAT_BAD_BIN = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_RUN,
    ST_DRAIN,
    ST_SCALE,
    ST_DONE
  } dds_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic load;
    logic init_step;
    logic issue;
    logic scale;
    logic out_load;
  } dds_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic query_ok;
    logic init_done;
    logic last_issue;
    logic out_free;
  } dds_stat_t;

endpackage

// ===== sv/dedoppler_drift_max_search.sv =====
// Dedoppler drift search top level: configuration registers, controller,
// datapath and sample store. Depends on dds_pkg, dds_ctrl, dds_dp, dds_store.
//
// A load beat writes one Q8.8 sample into the time-by-frequency store and
// leaves the block idle, so loads can follow back to back. A query beat walks
// every drift from -max_drift to +max_drift over all time_rows rows, reading
// one stored sample per cycle through the store's single read port. The block
// first steps the drift offset generator to its start value, then walks the
// paths, then covers the read latency, the scaling multiply and the result
// register. A query rejected for its configuration or bin skips these steps
// and goes straight to the result register. One item is worked on at a time;
// the result register holds a finished result while the next item is
// accepted. The store has no reset: a query must only touch entries loaded
// before. Configuration must be written only while the block is idle; the
// block itself does not enforce it.
`timescale 1ns / 1ps

module dedoppler_drift_max_search #(
  parameter int MAX_ROWS  = dds_pkg::DDS_MAX_ROWS,
  parameter int MAX_BINS  = dds_pkg::DDS_MAX_BINS,
  parameter int MAX_DRIFT = dds_pkg::DDS_MAX_DRIFT
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic                                     in_func,
  input  logic [dds_pkg::DDS_TIDX_W-1:0]           in_time_index,
  input  logic [dds_pkg::DDS_FIDX_W-1:0]           in_freq_index,
  input  logic signed [dds_pkg::DDS_SAMPLE_W-1:0]  in_sample,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic [1:0]                               out_status,
  output logic [dds_pkg::DDS_FIDX_W-1:0]           out_bin,
  output logic signed [dds_pkg::DDS_SNR_W-1:0]     out_best_snr,
  output logic signed [dds_pkg::DDS_BDRIFT_W-1:0]  out_best_drift,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [dds_pkg::DDS_CIDX_W-1:0]           cfg_index,
  input  logic [dds_pkg::DDS_CDATA_W-1:0]          cfg_data
);

  import dds_pkg::*;

  localparam int ADDR_W = $clog2(MAX_ROWS) + $clog2(MAX_BINS);

  // ---- Configuration registers -------------------------------------------
  logic [DDS_ROWS_W-1:0]  time_rows_r;
  logic [DDS_BINS_W-1:0]  freq_bins_r;
  logic [DDS_DRIFT_W-1:0] max_drift_r;
  logic [DDS_SCALE_W-1:0] inv_sqrt_rows_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_rows_r     <= DDS_ROWS_RST;
      freq_bins_r     <= DDS_BINS_RST;
      max_drift_r     <= DDS_DRIFT_RST;
      inv_sqrt_rows_r <= DDS_SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TIME_ROWS:     time_rows_r     <= cfg_data[DDS_ROWS_W-1:0];
        CFG_FREQ_BINS:     freq_bins_r     <= cfg_data[DDS_BINS_W-1:0];
        CFG_MAX_DRIFT:     max_drift_r     <= cfg_data[DDS_DRIFT_W-1:0];
        CFG_INV_SQRT_ROWS: inv_sqrt_rows_r <= cfg_data[DDS_SCALE_W-1:0];
        default:           time_rows_r     <= time_rows_r;
      endcase
    end
  end

  // ---- Blocks ------------------------------------------------------------
  dds_cmd_t  cmd;
  dds_stat_t stat;

  logic                    st_wr_en, st_rd_en;
  logic [ADDR_W-1:0]       st_wr_addr, st_rd_addr;
  logic [DDS_SAMPLE_W-1:0] st_wr_data, st_rd_data;

  dds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .stat     (stat),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  dds_dp #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_BINS  (MAX_BINS),
    .MAX_DRIFT (MAX_DRIFT),
    .ADDR_W    (ADDR_W)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .time_rows      (time_rows_r),
    .freq_bins      (freq_bins_r),
    .max_drift      (max_drift_r),
    .inv_sqrt_rows  (inv_sqrt_rows_r),
    .in_time_index  (in_time_index),
    .in_freq_index  (in_freq_index),
    .in_sample      (in_sample),
    .st_wr_en       (st_wr_en),
    .st_wr_addr     (st_wr_addr),
    .st_wr_data     (st_wr_data),
    .st_rd_en       (st_rd_en),
    .st_rd_addr     (st_rd_addr),
    .st_rd_data     (st_rd_data),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_bin        (out_bin),
    .out_best_snr   (out_best_snr),
    .out_best_drift (out_best_drift)
  );

  dds_store #(
    .ADDR_W (ADDR_W),
    .DATA_W (DDS_SAMPLE_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (st_wr_data),
    .rd_en   (st_rd_en),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data)
  );

  // ---- Assertions --------------------------------------------------------
  logic signed [DDS_BDRIFT_W-1:0] md_s;
  assign md_s = $signed({1'b0, max_drift_r});

  // An accepted query keeps the block busy for at least the next cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_func == FUNC_QUERY) |=> in_stall)
    else $error("input taken in the cycle after a query beat");

  // A rejected query reports a zero score and zero drift.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STAT_OK) |->
      (out_best_snr == '0 && out_best_drift == '0))
    else $error("error result carries a nonzero score or drift");

  // A good result names a drift inside the searched span.
  a_drift_span: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STAT_OK) |->
      (out_best_drift >= -md_s && out_best_drift <= md_s))
    else $error("best drift outside the searched span");

endmodule

// ===== sv/dds_store.sv =====
// Sample store: one write port and one registered read port.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module dds_store #(
  parameter int ADDR_W = 16,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [(1 << ADDR_W)];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/dds_ctrl.sv =====
// Controller of the drift search: sequences init, path walk, scaling, result.
// Depends on dds_pkg for the state type and the command and status structs.
`timescale 1ns / 1ps

module dds_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_func,
  input  dds_pkg::dds_stat_t stat,
  output dds_pkg::dds_cmd_t  cmd,
  output logic               in_stall
);

  import dds_pkg::*;

  dds_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_func == FUNC_QUERY) begin
          state_nxt = stat.query_ok ? ST_INIT : ST_DONE;
        end
      end
      ST_INIT: begin
        if (stat.init_done) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (stat.last_issue) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_DONE;
      ST_DONE: begin
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall      = 1'b0;
        cmd.start     = in_valid && in_func == FUNC_QUERY;
        cmd.load      = in_valid && in_func == FUNC_LOAD;
      end
      ST_INIT:  cmd.init_step = !stat.init_done;
      ST_RUN:   cmd.issue     = 1'b1;
      ST_DRAIN: cmd           = '0;
      ST_SCALE: cmd.scale     = 1'b1;
      ST_DONE:  cmd.out_load  = stat.out_free;
      default:  cmd           = '0;
    endcase
  end

endmodule

// ===== sv/dds_dp.sv =====
// Datapath of the drift search: path offset stepping, store addressing,
// path accumulation, best-path tracking, scaling and the result register.
// Depends on dds_pkg; drives the ports of dds_store.
`timescale 1ns / 1ps

module dds_dp #(
  parameter int MAX_ROWS  = dds_pkg::DDS_MAX_ROWS,
  parameter int MAX_BINS  = dds_pkg::DDS_MAX_BINS,
  parameter int MAX_DRIFT = dds_pkg::DDS_MAX_DRIFT,
  parameter int ADDR_W    = $clog2(MAX_ROWS) + $clog2(MAX_BINS)
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  dds_pkg::dds_cmd_t                        cmd,
  output dds_pkg::dds_stat_t                       stat,
  input  logic [dds_pkg::DDS_ROWS_W-1:0]           time_rows,
  input  logic [dds_pkg::DDS_BINS_W-1:0]           freq_bins,
  input  logic [dds_pkg::DDS_DRIFT_W-1:0]          max_drift,
  input  logic [dds_pkg::DDS_SCALE_W-1:0]          inv_sqrt_rows,
  input  logic [dds_pkg::DDS_TIDX_W-1:0]           in_time_index,
  input  logic [dds_pkg::DDS_FIDX_W-1:0]           in_freq_index,
  input  logic signed [dds_pkg::DDS_SAMPLE_W-1:0]  in_sample,
  output logic                                     st_wr_en,
  output logic [ADDR_W-1:0]                        st_wr_addr,
  output logic [dds_pkg::DDS_SAMPLE_W-1:0]         st_wr_data,
  output logic                                     st_rd_en,
  output logic [ADDR_W-1:0]                        st_rd_addr,
  input  logic [dds_pkg::DDS_SAMPLE_W-1:0]         st_rd_data,
  input  logic                                     out_stall,
  output logic                                     out_valid,
  output logic [1:0]                               out_status,
  output logic [dds_pkg::DDS_FIDX_W-1:0]           out_bin,
  output logic signed [dds_pkg::DDS_SNR_W-1:0]     out_best_snr,
  output logic signed [dds_pkg::DDS_BDRIFT_W-1:0]  out_best_drift
);

  import dds_pkg::*;

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = ADDR_W - RW;

  localparam logic signed [DDS_PROD_W-1:0] SNR_HI = DDS_PROD_W'(DDS_SNR_MAX);
  localparam logic signed [DDS_PROD_W-1:0] SNR_LO = DDS_PROD_W'(DDS_SNR_MIN);
  localparam logic signed [DDS_PROD_W-1:0] HALF_LSB = DDS_PROD_W'(32768);

  // ---- Query check --------------------------------------------------------
  logic       cfg_ok, bin_ok;
  logic [1:0] status_nxt;

  always_comb begin
    cfg_ok = time_rows >= 7'd2 && 32'(time_rows) <= MAX_ROWS &&
             32'(freq_bins) <= MAX_BINS && 32'(max_drift) <= MAX_DRIFT &&
             freq_bins > {4'd0, max_drift, 1'b0};
    bin_ok = in_freq_index >= {4'd0, max_drift} &&
             ({1'b0, in_freq_index} + {5'd0, max_drift}) < freq_bins;
    if (!cfg_ok) begin
      status_nxt = STAT_BAD_CFG;
    end else if (!bin_ok) begin
      status_nxt = STAT_BAD_BIN;
    end else begin
      status_nxt = STAT_OK;
    end
  end

  // ---- Path offset stepping -----------------------------------------------
  // For drift magnitude m, offset at row t is floor((2mt + den) / 2den).
  // a_r and b_r hold 2m as a_r * 2den + b_r; q_r and r_r hold the quotient
  // and remainder for the current row, so each step needs one compare.
  logic [6:0]        den;
  logic [7:0]        tden;
  logic [5:0]        mag_r, a_r;
  logic [7:0]        b_r, r_r;
  logic [6:0]        q_r, t_r;
  logic signed [6:0] d_r, md_s;
  logic [9:0]        bin_r;
  logic [1:0]        status_r;

  logic [8:0] b_inc, r_sum;
  logic       inc_wrap, dec_wrap, row_wrap;
  logic [7:0] b_up, b_dn, r_nxt;
  logic [5:0] a_up, a_dn;
  logic [6:0] q_nxt;
  logic       last_row;
  logic [10:0] col;

  assign den  = time_rows - 7'd1;
  assign tden = {den, 1'b0};
  assign md_s = $signed({1'b0, max_drift});

  assign b_inc    = {1'b0, b_r} + 9'd2;
  assign inc_wrap = b_inc >= {1'b0, tden};
  assign b_up     = inc_wrap ? 8'(b_inc - {1'b0, tden}) : b_inc[7:0];
  assign a_up     = a_r + 6'(inc_wrap);
  assign dec_wrap = b_r < 8'd2;
  assign b_dn     = dec_wrap ? 8'(b_r + tden - 8'd2) : 8'(b_r - 8'd2);
  assign a_dn     = a_r - 6'(dec_wrap);

  assign r_sum    = {1'b0, r_r} + {1'b0, b_r};
  assign row_wrap = r_sum >= {1'b0, tden};
  assign r_nxt    = row_wrap ? 8'(r_sum - {1'b0, tden}) : r_sum[7:0];
  assign q_nxt    = q_r + 7'(a_r) + 7'(row_wrap);

  assign last_row = t_r == den;
  assign col      = d_r[6] ? ({1'b0, bin_r} - 11'(q_r)) : ({1'b0, bin_r} + 11'(q_r));

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      bin_r    <= in_freq_index;
      status_r <= status_nxt;
      mag_r    <= '0;
      a_r      <= '0;
      b_r      <= '0;
      d_r      <= -md_s;
      t_r      <= '0;
      q_r      <= '0;
      r_r      <= {1'b0, den};
    end else if (cmd.init_step) begin
      mag_r <= mag_r + 6'd1;
      a_r   <= a_up;
      b_r   <= b_up;
    end else if (cmd.issue) begin
      if (last_row) begin
        t_r <= '0;
        q_r <= '0;
        r_r <= {1'b0, den};
        d_r <= d_r + 7'sd1;
        // Moving toward zero shrinks the magnitude; past zero it grows.
        if (d_r[6]) begin
          mag_r <= mag_r - 6'd1;
          a_r   <= a_dn;
          b_r   <= b_dn;
        end else begin
          mag_r <= mag_r + 6'd1;
          a_r   <= a_up;
          b_r   <= b_up;
        end
      end else begin
        t_r <= t_r + 7'd1;
        q_r <= q_nxt;
        r_r <= r_nxt;
      end
    end
  end

  // ---- Store ports -------------------------------------------------------
  assign st_wr_en   = cmd.load && 32'(in_time_index) < MAX_ROWS &&
                      32'(in_freq_index) < MAX_BINS;
  assign st_wr_addr = {RW'(in_time_index), CW'(in_freq_index)};
  assign st_wr_data = in_sample;
  assign st_rd_en   = cmd.issue;
  assign st_rd_addr = {RW'(t_r), CW'(col)};

  // ---- Accumulation of the registered read data ---------------------------
  logic                        tag_valid_r, tag_first_r, tag_last_r;
  logic signed [6:0]           tag_d_r;
  logic signed [DDS_SUM_W-1:0] acc_r, best_r, acc_sum, sample_ext;
  logic signed [6:0]           best_d_r;
  logic                        have_r;

  assign sample_ext = DDS_SUM_W'($signed(st_rd_data));
  assign acc_sum    = (tag_first_r ? '0 : acc_r) + sample_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_valid_r <= 1'b0;
      have_r      <= 1'b0;
    end else begin
      tag_valid_r <= cmd.issue;
      if (cmd.start) begin
        have_r <= 1'b0;
      end else if (tag_valid_r && tag_last_r) begin
        have_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    tag_first_r <= t_r == 7'd0;
    tag_last_r  <= last_row;
    tag_d_r     <= d_r;
    if (tag_valid_r) begin
      acc_r <= acc_sum;
      // Strict compare keeps the earliest drift on equal sums.
      if (tag_last_r && (!have_r || acc_sum > best_r)) begin
        best_r   <= acc_sum;
        best_d_r <= tag_d_r;
      end
    end
  end

  // ---- Scaling -----------------------------------------------------------
  logic signed [DDS_PROD_W-1:0] prod_nxt, prod_r, rnd, shifted;
  logic signed [DDS_SNR_W-1:0]  snr_sat;

  assign prod_nxt = DDS_PROD_W'(best_r) * DDS_PROD_W'($signed({1'b0, inv_sqrt_rows}));

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      prod_r <= prod_nxt;
    end
  end

  assign rnd     = prod_r + HALF_LSB;
  assign shifted = rnd >>> 16;

  always_comb begin
    if (shifted > SNR_HI) begin
      snr_sat = DDS_SNR_W'(SNR_HI);
    end else if (shifted < SNR_LO) begin
      snr_sat = DDS_SNR_W'(SNR_LO);
    end else begin
      snr_sat = shifted[DDS_SNR_W-1:0];
    end
  end

  // ---- Result register ---------------------------------------------------
  logic                          out_valid_r;
  logic [1:0]                    out_status_r;
  logic [DDS_FIDX_W-1:0]         out_bin_r;
  logic signed [DDS_SNR_W-1:0]   out_snr_r;
  logic signed [DDS_BDRIFT_W-1:0] out_drift_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= status_r;
      out_bin_r    <= bin_r;
      out_snr_r    <= (status_r == STAT_OK) ? snr_sat : '0;
      out_drift_r  <= (status_r == STAT_OK) ? best_d_r : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_bin        = out_bin_r;
  assign out_best_snr   = out_snr_r;
  assign out_best_drift = out_drift_r;

  // ---- Status to the controller ------------------------------------------
  assign stat.query_ok   = status_nxt == STAT_OK;
  assign stat.init_done  = mag_r == max_drift;
  assign stat.last_issue = last_row && d_r == md_s;
  assign stat.out_free   = !out_valid_r || !out_stall;

endmodule

// ===== test/testbench.sv =====
// Self-checking bench for the dedoppler drift search block: loads sample windows, runs
// drift queries under random valid/stall pressure and compares every result with a
// bit-true search model. Depends on dds_pkg and dedoppler_drift_max_search.
`timescale 1ns / 1ps

module testbench;
  import dds_pkg::*;

  localparam int WATCHDOG_LIMIT = 30000;
  localparam int HOLD_CYCLES    = 600;
  localparam int CFG_SETTLE     = 4;
  localparam int END_SETTLE     = 32;
  localparam int RAND_ITEMS     = 140;
  localparam int RAND_QUERIES   = 48;
  localparam int CALM_AFTER     = 40;

  typedef enum int {FILL_ANY, FILL_HIGH, FILL_LOW, FILL_TINY} fill_mode_t;

  typedef struct {
    logic [1:0]                     status;
    logic [DDS_FIDX_W-1:0]          bin;
    logic signed [DDS_SNR_W-1:0]    snr;
    logic signed [DDS_BDRIFT_W-1:0] drift;
  } search_result_t;

  // Bit-true copy of the search: its own sample array, registers and result queue.
  class drift_search_model;
    bit signed [DDS_SAMPLE_W-1:0] cells [DDS_MAX_ROWS][DDS_MAX_BINS];
    int rows_reg, bins_reg, drift_reg, scale_reg;
    search_result_t expected_q[$];
    int errors, loads_seen, queries_seen, writes_seen;
    int status_seen [3];

    function new();
      rows_reg  = DDS_ROWS_RST;
      bins_reg  = DDS_BINS_RST;
      drift_reg = DDS_DRIFT_RST;
      scale_reg = DDS_SCALE_RST;
    endfunction

    function void set_reg(logic [DDS_CIDX_W-1:0] idx, logic [DDS_CDATA_W-1:0] data);
      case (idx)
        CFG_TIME_ROWS:     rows_reg  = data[DDS_ROWS_W-1:0];
        CFG_FREQ_BINS:     bins_reg  = data[DDS_BINS_W-1:0];
        CFG_MAX_DRIFT:     drift_reg = data[DDS_DRIFT_W-1:0];
        CFG_INV_SQRT_ROWS: scale_reg = data[DDS_SCALE_W-1:0];
        default: ;
      endcase
      writes_seen++;
    endfunction

    // Bin offset of drift d at row t, rounded half away from zero.
    function int path_offset(int d, int t, int den);
      int mag, q;
      mag = (d < 0) ? -d : d;
      q = (2 * mag * t + den) / (2 * den);
      return (d < 0) ? -q : q;
    endfunction

    function void note_item(logic func, logic [DDS_TIDX_W-1:0] tidx,
                            logic [DDS_FIDX_W-1:0] fidx, logic signed [DDS_SAMPLE_W-1:0] smp);
      search_result_t want;
      longint path_sum, best_sum, prod, scale_l;
      int d, t;
      bit have;
      if (func == FUNC_LOAD) begin
        cells[tidx][fidx] = smp;
        loads_seen++;
        return;
      end
      want.status = STAT_OK;
      want.bin    = fidx;
      want.snr    = '0;
      want.drift  = '0;
      if (rows_reg < 2 || rows_reg > DDS_MAX_ROWS || bins_reg > DDS_MAX_BINS ||
          drift_reg > DDS_MAX_DRIFT || bins_reg <= 2 * drift_reg) begin
        want.status = STAT_BAD_CFG;
      end else if (int'(fidx) < drift_reg || int'(fidx) >= bins_reg - drift_reg) begin
        want.status = STAT_BAD_BIN;
      end else begin
        have = 1'b0;
        best_sum = 0;
        for (d = -drift_reg; d <= drift_reg; d++) begin
          path_sum = 0;
          for (t = 0; t < rows_reg; t++)
            path_sum += cells[t][int'(fidx) + path_offset(d, t, rows_reg - 1)];
          // Strictly greater keeps the earliest drift on equal sums.
          if (!have || path_sum > best_sum) begin
            have = 1'b1;
            best_sum = path_sum;
            want.drift = d;
          end
        end
        scale_l = scale_reg;
        prod = (best_sum * scale_l + 32768) >>> 16;
        if (prod > DDS_SNR_MAX) prod = DDS_SNR_MAX;
        if (prod < DDS_SNR_MIN) prod = DDS_SNR_MIN;
        want.snr = prod;
      end
      queries_seen++;
      status_seen[want.status]++;
      expected_q.push_back(want);
    endfunction

    function void check_result(search_result_t got);
      search_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat: status %0d bin %0d snr %0d drift %0d",
                 $time, got.status, got.bin, got.snr, got.drift);
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status) begin
        errors++;
        $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
      end
      if (got.bin !== want.bin) begin
        errors++;
        $display("%0t: bin expected %0d, got %0d", $time, want.bin, got.bin);
      end
      if (got.snr !== want.snr) begin
        errors++;
        $display("%0t: best_snr expected %0d, got %0d", $time, want.snr, got.snr);
      end
      if (got.drift !== want.drift) begin
        errors++;
        $display("%0t: best_drift expected %0d, got %0d", $time, want.drift, got.drift);
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  logic                           in_func;
  logic [DDS_TIDX_W-1:0]          in_time_index;
  logic [DDS_FIDX_W-1:0]          in_freq_index;
  logic signed [DDS_SAMPLE_W-1:0] in_sample;
  logic                           out_valid;
  logic                           out_stall;
  logic [1:0]                     out_status;
  logic [DDS_FIDX_W-1:0]          out_bin;
  logic signed [DDS_SNR_W-1:0]    out_best_snr;
  logic signed [DDS_BDRIFT_W-1:0] out_best_drift;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [DDS_CIDX_W-1:0]          cfg_index;
  logic [DDS_CDATA_W-1:0]         cfg_data;

  drift_search_model sb = new();

  // Stimulus-side view of the current setting and of which cells hold data.
  int set_rows, set_bins, set_md;
  int load_mark [DDS_MAX_ROWS][DDS_MAX_BINS];
  int query_serial;
  int items_sent;
  int gap_pct, stall_pct;
  int quiet_cycles;
  int settings_used;
  fill_mode_t fill_mode;
  bit calm;
  bit hold_req;

  dedoppler_drift_max_search i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_time_index  (in_time_index),
    .in_freq_index  (in_freq_index),
    .in_sample      (in_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_bin        (out_bin),
    .out_best_snr   (out_best_snr),
    .out_best_drift (out_best_drift),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin : beat_monitor
    search_result_t got;
    bit moved;
    if (rst_n) begin
      moved = 1'b0;
      if (cfg_valid && cfg_ready) begin
        sb.set_reg(cfg_index, cfg_data);
        moved = 1'b1;
      end
      if (in_valid && !in_stall) begin
        sb.note_item(in_func, in_time_index, in_freq_index, in_sample);
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        got.status = out_status;
        got.bin    = out_bin;
        got.snr    = out_best_snr;
        got.drift  = out_best_drift;
        sb.check_result(got);
        moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall = 1'b0;
      end else if (!calm && $urandom_range(100, 1) <= stall_pct) begin
        out_stall = 1'b1;
        repeat ($urandom_range(11, 1)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  function automatic logic signed [DDS_SAMPLE_W-1:0] pick_sample(fill_mode_t mode);
    int v;
    case (mode)
      FILL_HIGH: return ($urandom_range(7, 0) != 0) ? 16'sh7FFF : 16'($urandom);
      FILL_LOW:  return ($urandom_range(7, 0) != 0) ? 16'sh8000 : 16'($urandom);
      FILL_TINY: begin
        v = int'($urandom_range(4, 0)) - 2;
        return 16'(v);
      end
      default:   return 16'($urandom);
    endcase
  endfunction

  // Presents one beat and returns at the edge that takes it; valid stays high
  // unless a random gap follows.
  task automatic send_item(input logic func, input logic [DDS_TIDX_W-1:0] tidx,
                           input logic [DDS_FIDX_W-1:0] fidx,
                           input logic signed [DDS_SAMPLE_W-1:0] smp);
    @(negedge clk);
    in_valid      = 1'b1;
    in_func       = func;
    in_time_index = tidx;
    in_freq_index = fidx;
    in_sample     = smp;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (func == FUNC_LOAD && load_mark[tidx][fidx] == 0) load_mark[tidx][fidx] = -1;
    if (!calm && $urandom_range(100, 1) <= gap_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(11, 1) - 1) @(negedge clk);
    end
  endtask

  task automatic query_bin(input int bin);
    send_item(FUNC_QUERY, $urandom, bin, $urandom);
  endtask

  // Loads every cell the query at this bin will read; with refresh set, cells
  // already holding data are overwritten once per query as well.
  task automatic load_path_cells(input int bin, input bit refresh);
    int d, t, col;
    query_serial++;
    for (d = -set_md; d <= set_md; d++) begin
      for (t = 0; t < set_rows; t++) begin
        col = bin + sb.path_offset(d, t, set_rows - 1);
        if (load_mark[t][col] == 0 || (refresh && load_mark[t][col] != query_serial)) begin
          send_item(FUNC_LOAD, t, col, pick_sample(fill_mode));
          load_mark[t][col] = query_serial;
        end
      end
    end
  endtask

  task automatic wait_results_done();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    // A load may still be in flight after the last result.
    repeat (CFG_SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [DDS_CIDX_W-1:0] idx, input int data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_setting(input int rows_v, input int bins_v, input int md_v,
                               input int inv_v);
    wait_results_done();
    write_reg(CFG_TIME_ROWS, rows_v);
    write_reg(CFG_FREQ_BINS, bins_v);
    write_reg(CFG_MAX_DRIFT, md_v);
    write_reg(CFG_INV_SQRT_ROWS, inv_v);
    @(negedge clk);
    cfg_valid = 1'b0;
    set_rows = rows_v;
    set_bins = bins_v;
    set_md   = md_v;
    settings_used++;
  endtask

  initial begin : stimulus
    int phase, k, nq, bin, rows_v, bins_v, md_v, inv_v, directed_items, rand_queries;
    bit bad_cfg, want_bad, pressure;
    in_valid      = 1'b0;
    in_func       = FUNC_LOAD;
    in_time_index = '0;
    in_freq_index = '0;
    in_sample     = '0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_TIME_ROWS;
    cfg_data      = '0;
    gap_pct       = 20;
    stall_pct     = 20;
    fill_mode     = FILL_ANY;
    rst_n         = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Smallest legal search: two rows, three bins, drift of one.
    apply_setting(2, 3, 1, 65535);
    send_item(FUNC_LOAD, 0, 1, 16'sh7FFF);
    send_item(FUNC_LOAD, 1, 0, 16'sh8000);
    send_item(FUNC_LOAD, 1, 1, 16'sd5);
    send_item(FUNC_LOAD, 1, 2, 16'sh7FFF);
    query_bin(1);
    query_bin(0);
    query_bin(2);
    query_bin(1023);
    send_item(FUNC_LOAD, 63, 1023, 16'sh8000);
    // Equal sums at drift -1 and +1: the earlier drift must win.
    send_item(FUNC_LOAD, 1, 0, 16'sh7FFF);
    query_bin(1);
    apply_setting(2, 3, 1, 0);
    query_bin(1);
    // Each of these settings is rejected as a whole.
    apply_setting(2, 2, 1, 40000);
    query_bin(1);
    apply_setting(2, 2047, 1, 40000);
    query_bin(1);
    apply_setting(1, 3, 1, 40000);
    query_bin(1);
    apply_setting(127, 3, 1, 40000);
    query_bin(1);
    apply_setting(2, 3, 63, 40000);
    query_bin(1);
    // No drift, top bin, negative sum that needs rounding toward minus infinity.
    apply_setting(2, 1024, 0, 40000);
    send_item(FUNC_LOAD, 0, 1023, 16'sh8000);
    send_item(FUNC_LOAD, 1, 1023, -16'sd1);
    query_bin(1023);
    directed_items = items_sent;

    phase = 0;
    rand_queries = 0;
    while (items_sent - directed_items < RAND_ITEMS || rand_queries < RAND_QUERIES) begin
      bad_cfg   = 1'b0;
      pressure  = 1'b0;
      nq        = $urandom_range(8, 3);
      inv_v     = $urandom_range(65535, 0);
      gap_pct   = 20 * $urandom_range(2, 0);
      stall_pct = 20 * $urandom_range(2, 0);
      case (phase)
        0: begin
          rows_v = 16; md_v = 3; bins_v = $urandom_range(1024, 7); inv_v = 65535;
          fill_mode = FILL_HIGH; nq = 4;
        end
        1: begin
          rows_v = 64; md_v = 32; bins_v = 1024; fill_mode = FILL_ANY; nq = 2;
        end
        2: begin
          rows_v = 3; md_v = 1; bins_v = 300; fill_mode = FILL_TINY; nq = 5;
          pressure = 1'b1; gap_pct = 0;
        end
        3: begin
          rows_v = 12; md_v = 2; bins_v = 1024; inv_v = 65535; fill_mode = FILL_LOW; nq = 4;
        end
        4: begin
          rows_v = 2; md_v = 32; bins_v = 65; fill_mode = FILL_ANY; nq = 3;
        end
        5: begin
          rows_v = 64; md_v = 1; bins_v = $urandom_range(1024, 3); fill_mode = FILL_TINY;
          nq = 3;
        end
        default: begin
          rows_v = ($urandom_range(5, 0) == 0) ? 2 : $urandom_range(12, 2);
          md_v   = ($urandom_range(4, 0) == 0) ? 0 : $urandom_range(6, 1);
          case ($urandom_range(3, 0))
            0: bins_v = 2 * md_v + 1;
            1: bins_v = 1024;
            default: bins_v = $urandom_range(1024, 2 * md_v + 1);
          endcase
          case ($urandom_range(7, 0))
            0: inv_v = 0;
            1, 2: inv_v = 65535;
            default: ;
          endcase
          fill_mode = fill_mode_t'($urandom_range(3, 0));
          if ($urandom_range(7, 0) == 0) begin
            bad_cfg = 1'b1;
            case ($urandom_range(4, 0))
              0: rows_v = $urandom_range(1, 0);
              1: rows_v = $urandom_range(127, 65);
              2: md_v   = $urandom_range(63, 33);
              3: bins_v = $urandom_range(2 * md_v, 0);
              default: bins_v = $urandom_range(2047, 1025);
            endcase
          end
        end
      endcase
      apply_setting(rows_v, bins_v, md_v, inv_v);
      if (pressure) hold_req = 1'b1;
      for (k = 0; k < nq; k++) begin
        if (rand_queries >= CALM_AFTER) calm = 1'b1;
        if ($urandom_range(4, 0) == 0)
          send_item(FUNC_LOAD, $urandom, $urandom, pick_sample(FILL_ANY));
        want_bad = ($urandom_range(6, 0) == 0);
        if (bad_cfg) begin
          bin = $urandom_range(1023, 0);
        end else if (want_bad && set_md > 0 &&
                     (set_bins - set_md > 1023 || $urandom_range(1, 0) == 0)) begin
          bin = $urandom_range(set_md - 1, 0);
        end else if (want_bad && set_bins - set_md <= 1023) begin
          bin = $urandom_range(1023, set_bins - set_md);
        end else begin
          bin = $urandom_range(set_bins - set_md - 1, set_md);
          load_path_cells(bin, fill_mode != FILL_ANY);
        end
        query_bin(bin);
        rand_queries++;
      end
      phase++;
    end

    wait_results_done();
    repeat (END_SETTLE) @(posedge clk);
    $display("Covered %0d loads and %0d queries: %0d searched, %0d bad settings, %0d bad bins.",
             sb.loads_seen, sb.queries_seen, sb.status_seen[STAT_OK],
             sb.status_seen[STAT_BAD_CFG], sb.status_seen[STAT_BAD_BIN]);
    $display("%0d register writes over %0d settings, up to 64 rows and drift 32, %0d errors.",
             sb.writes_seen, settings_used, sb.errors);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
